/* hw/rtl/polynomial_value_and_derivatives_defines.svh */
// Assertion macros used by the checker file.
`ifndef POLYNOMIAL_VALUE_AND_DERIVATIVES_DEFINES_SVH
`define POLYNOMIAL_VALUE_AND_DERIVATIVES_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PDV_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PDV_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/pdv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pdv_pkg;

    localparam int COEF_REGS      = 8;
    localparam int NUM_COEFFS_DEF = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int DATA_W         = 32;
    localparam int W1_W           = 35;
    localparam int W2_W           = 38;
    localparam int PROD_W         = 64;
    localparam int SUM_W          = 66;
    localparam int Q_FRAC         = 16;

    typedef logic signed [DATA_W-1:0] t_q;
    typedef logic signed [W1_W-1:0]   t_w1;
    typedef logic signed [W2_W-1:0]   t_w2;

    localparam t_q Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam t_q Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic signed [DATA_W-1:0] f0;
        logic signed [DATA_W-1:0] f1;
        logic signed [DATA_W-1:0] f2;
        logic                     ovf;
    } t_acc;

endpackage

`default_nettype wire

/* hw/rtl/pdv_coef_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module pdv_coef_regs
    import pdv_pkg::*;
#(
    parameter int NUM_COEFFS = NUM_COEFFS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic signed [31:0]   i_cfg_data,
    output t_q                        o_w0 [NUM_COEFFS],
    output t_w1                       o_w1 [NUM_COEFFS],
    output t_w2                       o_w2 [NUM_COEFFS]
);

    t_q  r_w0 [NUM_COEFFS];
    t_w1 r_w1 [NUM_COEFFS];
    t_w2 r_w2 [NUM_COEFFS];
    t_w1 n_w1 [NUM_COEFFS];
    t_w2 n_w2 [NUM_COEFFS];

    // Each register also keeps its derivative weights k*c and k*(k-1)*c.
    for (genvar i = 0; i < NUM_COEFFS; i++) begin : g_reg
        localparam t_w1 M1 = W1_W'(i);
        localparam t_w2 M2 = W2_W'(i * (i - 1));

        always_comb begin
            n_w1[i] = W1_W'(i_cfg_data) * M1;
            n_w2[i] = W2_W'(i_cfg_data) * M2;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_w0[i] <= '0;
                r_w1[i] <= '0;
                r_w2[i] <= '0;
            end else if (i_cfg_we && (i_cfg_index == CFG_IDX_W'(i))) begin
                r_w0[i] <= i_cfg_data;
                r_w1[i] <= n_w1[i];
                r_w2[i] <= n_w2[i];
            end
        end

        assign o_w0[i] = r_w0[i];
        assign o_w1[i] = r_w1[i];
        assign o_w2[i] = r_w2[i];
    end

endmodule

`default_nettype wire

/* hw/rtl/pdv_step.sv */
`timescale 1ns / 1ps
`default_nettype none

module pdv_step
    import pdv_pkg::*;
#(
    parameter int K = 0
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_stall,
    input  wire t_q    i_x,
    input  wire t_acc  i_acc,
    input  wire t_q    i_w0,
    input  wire t_w1   i_w1,
    input  wire t_w2   i_w2,
    output logic       o_valid,
    input  wire logic  i_stall,
    output t_q         o_x,
    output t_acc       o_acc
);

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     ovf;
    } t_sat;

    localparam logic ACT1 = (K >= 1);
    localparam logic ACT2 = (K >= 2);
    localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) <<< (Q_FRAC - 1);

    function automatic t_sat sat_q(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-Q_FRAC-DATA_W:0] hi;
        t_sat r;
        hi    = s[SUM_W-1:Q_FRAC+DATA_W-1];
        r.ovf = !((&hi) || !(|hi));
        if (r.ovf) begin
            r.val = s[SUM_W-1] ? Q_MIN : Q_MAX;
        end else begin
            r.val = s[Q_FRAC+DATA_W-1:Q_FRAC];
        end
        return r;
    endfunction

    logic                     r_a_valid;
    t_q                       r_a_x;
    t_acc                     r_a_acc;
    logic signed [PROD_W-1:0] r_a_p0, r_a_p1, r_a_p2;
    logic                     r_b_valid;
    t_q                       r_b_x;
    t_acc                     r_b_acc;

    logic signed [PROD_W-1:0] n_a_p0, n_a_p1, n_a_p2;
    logic signed [SUM_W-1:0]  s0, s1, s2;
    t_sat                     q0, q1, q2;
    t_acc                     n_b_acc;
    logic                     a_move, b_move;

    assign b_move  = !r_b_valid || !i_stall;
    assign a_move  = !r_a_valid || b_move;
    assign o_stall = !a_move;

    always_comb begin
        n_a_p0 = i_acc.f0 * i_x;
        n_a_p1 = i_acc.f1 * i_x;
        n_a_p2 = i_acc.f2 * i_x;
    end

    // The weight sits above the fraction bits, so one sum gives round and add.
    always_comb begin
        s0 = SUM_W'(r_a_p0) + RND + (SUM_W'(i_w0) <<< Q_FRAC);
        s1 = SUM_W'(r_a_p1) + RND + (SUM_W'(i_w1) <<< Q_FRAC);
        s2 = SUM_W'(r_a_p2) + RND + (SUM_W'(i_w2) <<< Q_FRAC);
        q0 = sat_q(s0);
        q1 = sat_q(s1);
        q2 = sat_q(s2);
        n_b_acc.f0  = q0.val;
        n_b_acc.f1  = ACT1 ? q1.val : r_a_acc.f1;
        n_b_acc.f2  = ACT2 ? q2.val : r_a_acc.f2;
        n_b_acc.ovf = r_a_acc.ovf | q0.ovf | (ACT1 & q1.ovf) | (ACT2 & q2.ovf);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_move) begin
                r_a_valid <= i_valid;
            end
            if (b_move) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move && i_valid) begin
            r_a_x   <= i_x;
            r_a_acc <= i_acc;
            r_a_p0  <= n_a_p0;
            r_a_p1  <= n_a_p1;
            r_a_p2  <= n_a_p2;
        end
        if (b_move && r_a_valid) begin
            r_b_x   <= r_a_x;
            r_b_acc <= n_b_acc;
        end
    end

    assign o_valid = r_b_valid;
    assign o_x     = r_b_x;
    assign o_acc   = r_b_acc;

endmodule

`default_nettype wire

/* hw/rtl/polynomial_value_and_derivatives.sv */
// Evaluates a polynomial of up to NUM_COEFFS terms at a point, with its first
// and second derivatives, in signed Q16.16 with saturation.
// The input channel (i_valid, o_stall) carries one word with the point
// i_x_position. The output channel (o_valid, i_stall) carries one word with
// the value, both derivatives and a flag that any Horner step saturated.
// Coefficients are written through i_cfg_we, i_cfg_index and i_cfg_data; the
// user must write them only while no word is in flight (the block does not
// enforce this). Indexes at or above NUM_COEFFS have no effect. Each Horner
// step is two register stages, a multiply and then a round, add and clamp.
// Unless i_stall holds it, one word is accepted and one result given per cycle.
// When the receiver stalls, the last stage holds its word and earlier stages
// keep filling empty slots; o_stall rises only once the pipeline is full.
// Reset clears all coefficients to zero and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module polynomial_value_and_derivatives
    import pdv_pkg::*;
#(
    parameter int NUM_COEFFS = NUM_COEFFS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic signed [31:0]   i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic signed [31:0]   i_x_position,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic signed [31:0]        o_poly_value,
    output logic signed [31:0]        o_first_derivative,
    output logic signed [31:0]        o_second_derivative,
    output logic                      o_overflow
);

    t_q   w0 [NUM_COEFFS];
    t_w1  w1 [NUM_COEFFS];
    t_w2  w2 [NUM_COEFFS];

    logic s_valid [NUM_COEFFS+1];
    logic s_stall [NUM_COEFFS+1];
    t_q   s_x     [NUM_COEFFS+1];
    t_acc s_acc   [NUM_COEFFS+1];

    pdv_coef_regs #(
        .NUM_COEFFS(NUM_COEFFS)
    ) u_coef (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_w0       (w0),
        .o_w1       (w1),
        .o_w2       (w2)
    );

    assign s_valid[0] = i_valid;
    assign s_x[0]     = i_x_position;
    assign s_acc[0]   = '0;
    assign o_stall    = s_stall[0];

    for (genvar j = 0; j < NUM_COEFFS; j++) begin : g_step
        localparam int K = NUM_COEFFS - 1 - j;

        pdv_step #(
            .K(K)
        ) u_step (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(s_valid[j]),
            .o_stall(s_stall[j]),
            .i_x    (s_x[j]),
            .i_acc  (s_acc[j]),
            .i_w0   (w0[K]),
            .i_w1   (w1[K]),
            .i_w2   (w2[K]),
            .o_valid(s_valid[j+1]),
            .i_stall(s_stall[j+1]),
            .o_x    (s_x[j+1]),
            .o_acc  (s_acc[j+1])
        );
    end

    assign s_stall[NUM_COEFFS] = i_stall;

    assign o_valid             = s_valid[NUM_COEFFS];
    assign o_poly_value        = s_acc[NUM_COEFFS].f0;
    assign o_first_derivative  = s_acc[NUM_COEFFS].f1;
    assign o_second_derivative = s_acc[NUM_COEFFS].f2;
    assign o_overflow          = s_acc[NUM_COEFFS].ovf;

endmodule

`default_nettype wire

/* hw/rtl/pdv_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "polynomial_value_and_derivatives_defines.svh"

module pdv_checker
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_stall,
    input wire logic                 o_valid,
    input wire logic                 i_stall,
    input wire logic signed [31:0]   o_poly_value,
    input wire logic signed [31:0]   o_first_derivative,
    input wire logic signed [31:0]   o_second_derivative,
    input wire logic                 o_overflow
);

    `PDV_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_poly_value) && $stable(o_first_derivative)
        && $stable(o_second_derivative) && $stable(o_overflow),
        "Stalled output word changed.")
    `PDV_ASSERT_IMP(a_stall_only_full, i_clk, i_rst_n, !o_valid || !i_stall, !o_stall,
        "Input stalled although the output side is moving.")
    `PDV_ASSERT_IMP(a_empty_after_reset, i_clk, i_rst_n, $past(!i_rst_n), !o_valid,
        "Output word present right after reset.")

endmodule

bind polynomial_value_and_derivatives pdv_checker u_pdv_checker (.*);

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import pdv_pkg::*;

    localparam int N_TERMS   = NUM_COEFFS_DEF;
    localparam int HOLD_LEN  = 300;
    localparam int RAND_SETS = 8;
    localparam int SET_ITEMS = 55;

    typedef enum int {
        MIX_SMALL,
        MIX_FULL,
        MIX_MIXED,
        MIX_LOW_DEGREE
    } coef_mix_e;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic signed [31:0]   i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic signed [31:0]   i_x_position = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic signed [31:0]   o_poly_value;
    logic signed [31:0]   o_first_derivative;
    logic signed [31:0]   o_second_derivative;
    logic                 o_overflow;

    t_q   coef_now[COEF_REGS];
    t_q   coef_plan[COEF_REGS];
    t_q   x_pending[$];
    t_acc expected_evals[$];

    bit   x_taken = 1'b0;
    bit   calm = 1'b0;
    bit   hold_pending = 1'b0;
    bit   hold_done = 1'b0;
    int   hold_left = 0;
    int   mismatches = 0;
    int   points_accepted = 0;
    int   results_checked = 0;
    int   settings_loaded = 0;
    int   blocked_cycles = 0;

    polynomial_value_and_derivatives #(
        .NUM_COEFFS(N_TERMS)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_x_position       (i_x_position),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_poly_value       (o_poly_value),
        .o_first_derivative (o_first_derivative),
        .o_second_derivative(o_second_derivative),
        .o_overflow         (o_overflow)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Three Horner chains over the same point; chain d uses the d-th derivative weights.
    function automatic t_acc eval_poly_derivs(t_q x);
        t_acc   r;
        longint acc;
        longint w;
        longint s;
        longint f[3];
        int     mult;
        logic   sat;
        sat = 1'b0;
        for (int d = 0; d < 3; d++) begin
            acc = 0;
            for (int k = N_TERMS - 1; k >= d; k--) begin
                mult = 1;
                for (int j = 0; j < d; j++) begin
                    mult = mult * (k - j);
                end
                w = longint'(coef_now[k]) * mult;
                s = ((acc * longint'(x) + 32768) >>> Q_FRAC) + w;
                if (s > longint'(Q_MAX)) begin
                    s = Q_MAX;
                    sat = 1'b1;
                end else if (s < longint'(Q_MIN)) begin
                    s = Q_MIN;
                    sat = 1'b1;
                end
                acc = s;
            end
            f[d] = acc;
        end
        r.f0  = t_q'(f[0]);
        r.f1  = t_q'(f[1]);
        r.f2  = t_q'(f[2]);
        r.ovf = sat;
        return r;
    endfunction

    function automatic t_q rand_signed(int bits);
        return t_q'(int'($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1)));
    endfunction

    function automatic t_q pick_coef(coef_mix_e mix, int k);
        int r;
        r = $urandom_range(0, 4);
        case (mix)
            MIX_SMALL: begin
                return rand_signed(18);
            end
            MIX_FULL: begin
                return t_q'($urandom);
            end
            MIX_LOW_DEGREE: begin
                return (k <= 3) ? rand_signed(20) : t_q'(0);
            end
            default: begin
                case (r)
                    0: return rand_signed(18);
                    1: return t_q'($urandom);
                    2: return Q_MAX;
                    3: return Q_MIN;
                    default: return t_q'(0);
                endcase
            end
        endcase
    endfunction

    function automatic t_q pick_x();
        t_q corners[8] = '{32'sh0, 32'sh1, -32'sh1, Q_MAX, Q_MIN,
                           32'sh10000, -32'sh10000, 32'sh8000};
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return rand_signed(20);
        end else if (r < 85) begin
            return t_q'($urandom);
        end
        return corners[$urandom_range(0, 7)];
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        if (mismatches <= 40) begin
            $display("MISMATCH at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        end
    endtask

    task automatic write_coefs();
        for (int i = 0; i < COEF_REGS; i++) begin
            @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(i);
            i_cfg_data  <= coef_plan[i];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        for (int i = 0; i < COEF_REGS; i++) begin
            coef_now[i] = coef_plan[i];
        end
        settings_loaded++;
    endtask

    task automatic fill_coefs(t_q v);
        for (int i = 0; i < COEF_REGS; i++) begin
            coef_plan[i] = v;
        end
    endtask

    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (x_pending.size() != 0 || i_valid || expected_evals.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin : drive_points
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || x_taken) begin
            if (x_pending.size() != 0 && (calm || $urandom_range(0, 99) >= 28)) begin
                i_valid      <= 1'b1;
                i_x_position <= x_pending.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : drive_stall
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_pending && !hold_done) begin
            i_stall   <= 1'b1;
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else begin
            i_stall <= !calm && ($urandom_range(0, 99) < 28);
        end
    end

    always @(posedge i_clk) begin : watch
        t_acc want;
        if (!i_rst_n) begin
            x_taken = 1'b0;
        end else begin
            x_taken = i_valid && !o_stall;
            if (x_taken) begin
                expected_evals.push_back(eval_poly_derivs(i_x_position));
                points_accepted++;
            end
            if (i_valid && o_stall) begin
                blocked_cycles++;
            end
            if (o_valid && !i_stall) begin
                if (expected_evals.size() == 0) begin
                    report_mismatch("result word with nothing expected, poly_value",
                                    o_poly_value, 0);
                end else begin
                    want = expected_evals.pop_front();
                    results_checked++;
                    if (o_poly_value !== want.f0) begin
                        report_mismatch("poly_value", o_poly_value, want.f0);
                    end
                    if (o_first_derivative !== want.f1) begin
                        report_mismatch("first_derivative", o_first_derivative, want.f1);
                    end
                    if (o_second_derivative !== want.f2) begin
                        report_mismatch("second_derivative", o_second_derivative, want.f2);
                    end
                    if (o_overflow !== want.ovf) begin
                        report_mismatch("overflow", o_overflow, want.ovf);
                    end
                end
            end
        end
    end

    initial begin
        t_q zero_x[3]   = '{Q_MAX, Q_MIN, 32'sh0};
        t_q unit_x[10]  = '{32'sh0, 32'sh10000, -32'sh10000, 32'sh8000, -32'sh8000,
                            32'sh1, -32'sh1, Q_MAX, Q_MIN, 32'sh20000};
        t_q mid_x[2]    = '{32'sh10000, 32'sh20000};
        t_q max_x[3]    = '{32'sh10000, -32'sh10000, 32'sh0};
        t_q min_x[3]    = '{32'sh10000, 32'sh8000, -32'sh10000};
        coef_mix_e mix;

        for (int i = 0; i < COEF_REGS; i++) begin
            coef_now[i]  = '0;
            coef_plan[i] = '0;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Coefficients straight out of reset must all read as zero.
        foreach (zero_x[i]) x_pending.push_back(zero_x[i]);
        wait_idle();

        fill_coefs(32'sh10000);
        write_coefs();
        foreach (unit_x[i]) x_pending.push_back(unit_x[i]);
        wait_idle();

        // At x = 1.0 the middle step of the value chain clamps although the ideal value fits.
        fill_coefs(32'sh0);
        coef_plan[2] = 32'sh6000_0000;
        coef_plan[1] = 32'sh6000_0000;
        coef_plan[0] = Q_MIN;
        write_coefs();
        foreach (mid_x[i]) x_pending.push_back(mid_x[i]);
        wait_idle();

        fill_coefs(Q_MAX);
        write_coefs();
        foreach (max_x[i]) x_pending.push_back(max_x[i]);
        wait_idle();

        fill_coefs(Q_MIN);
        write_coefs();
        foreach (min_x[i]) x_pending.push_back(min_x[i]);
        wait_idle();

        for (int set = 0; set < RAND_SETS; set++) begin
            mix = coef_mix_e'(set % 4);
            for (int k = 0; k < COEF_REGS; k++) begin
                coef_plan[k] = pick_coef(mix, k);
            end
            write_coefs();
            calm = (set == 2);
            hold_pending = (set == 5);
            for (int n = 0; n < SET_ITEMS; n++) begin
                x_pending.push_back(pick_x());
            end
            wait_idle();
            calm = 1'b0;
        end

        repeat (2 * N_TERMS + 8) @(posedge i_clk);
        if (expected_evals.size() != 0) begin
            report_mismatch("result words never delivered", expected_evals.size(), 0);
        end
        $display("Checked %0d result words for %0d points across %0d coefficient sets.",
                 results_checked, points_accepted, settings_loaded);
        $display("The block refused input for %0d cycles while the receiver held off.",
                 blocked_cycles);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timed out waiting for results.");
        $display("Mismatches found");
        $finish;
    end

endmodule
